>>> rtl/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and codes for the page buffer pool frame table.
// ----------------------------------------------------------------------------
package pbl_pkg;
   localparam int CMD_W   = 2;
   localparam int PAGE_W  = 32;
   localparam int KIND_W  = 3;
   localparam int FRAME_W = 6;
   localparam int MARK_W  = 7;
   localparam int PIN_W   = 16;
   localparam int STAMP_W = 64;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

   localparam logic [KIND_W-1:0] KIND_HIT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FILL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WB   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FAIL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW  = 1'd1;

   // operation broadcast to every cell
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_HIT   = 3'd1;
   localparam logic [2:0] OP_FILL  = 3'd2;
   localparam logic [2:0] OP_UNPIN = 3'd3;
   localparam logic [2:0] OP_DIRTY = 3'd4;
   localparam logic [2:0] OP_CLEAN = 3'd5;

   typedef struct packed {
      logic [2:0]         op;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
      logic [STAMP_W-1:0] stamp;
   } cell_op_type;

   // candidate carried along the chain
   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] frame;
      logic [STAMP_W-1:0] stamp;
      logic [PAGE_W-1:0]  tag;
      logic               dirty;
   } cand_type;

   // per-pass scan request, what each pass selects
   typedef struct packed {
      logic [PAGE_W-1:0] page;
   } scan_type;

   typedef struct packed {
      cand_type          hit;
      cand_type          inval;
      cand_type          lru;
      cand_type          lru_dirty;
      cand_type          first_dirty;
      logic [MARK_W-1:0] dirty_cnt;
   } chain_type;
endpackage

>>> rtl/pbl_if.sv
// ----------------------------------------------------------------------------
// pbl_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pbl_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pbl_cell.sv
// ----------------------------------------------------------------------------
// pbl_cell
// One frame: holds tag, flags, pin count and stamp; merges its entry into
// the candidates handed down the chain.
// ----------------------------------------------------------------------------
module pbl_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  pbl_pkg::cell_op_type op,
   input  pbl_pkg::scan_type  scan,
   input  pbl_pkg::chain_type chain_in,
   output pbl_pkg::chain_type chain_out
);
   import pbl_pkg::*;

   localparam logic [FRAME_W-1:0] ME = FRAME_W'(IDX);

   logic [PAGE_W-1:0]  tag_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic               valid_ff, dirty_ff;
   logic [PIN_W-1:0]   pin_ff;
   logic               sel;
   cand_type           mine;

   assign sel = (op.frame == ME);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         pin_ff   <= '0;
      end else if (sel) begin
         case (op.op)
            OP_HIT: begin
               if (pin_ff != '1) pin_ff <= pin_ff + 1'b1;
            end
            OP_FILL: begin
               valid_ff <= 1'b1;
               dirty_ff <= 1'b0;
               pin_ff   <= PIN_W'(1);
            end
            OP_UNPIN: begin
               if (pin_ff != '0) pin_ff <= pin_ff - 1'b1;
            end
            OP_DIRTY: dirty_ff <= 1'b1;
            OP_CLEAN: dirty_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel && op.op == OP_FILL) tag_ff <= op.page;
      if (sel && (op.op == OP_FILL || op.op == OP_HIT)) stamp_ff <= op.stamp;
   end

   assign mine = '{found: 1'b1, frame: ME, stamp: stamp_ff, tag: tag_ff,
                   dirty: dirty_ff};

   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit.found && valid_ff && tag_ff == scan.page)
         chain_out.hit = mine;
      if (!chain_in.inval.found && !valid_ff)
         chain_out.inval = mine;
      if (valid_ff && pin_ff == '0 &&
          (!chain_in.lru.found || stamp_ff < chain_in.lru.stamp))
         chain_out.lru = mine;
      if (valid_ff && dirty_ff && pin_ff == '0 &&
          (!chain_in.lru_dirty.found || stamp_ff < chain_in.lru_dirty.stamp))
         chain_out.lru_dirty = mine;
      if (!chain_in.first_dirty.found && valid_ff && dirty_ff)
         chain_out.first_dirty = mine;
      if (valid_ff && dirty_ff)
         chain_out.dirty_cnt = chain_in.dirty_cnt + 1'b1;
   end
endmodule

>>> rtl/pbl_array.sv
// ----------------------------------------------------------------------------
// pbl_array
// Row of frame cells; the candidate chain is registered every eight cells.
// ----------------------------------------------------------------------------
module pbl_array #(
   parameter int FRAMES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  pbl_pkg::cell_op_type op,
   input  pbl_pkg::scan_type  scan,
   output pbl_pkg::chain_type result
);
   import pbl_pkg::*;

   localparam int SEG = 8;

   chain_type link [FRAMES+1];
   chain_type link_out [FRAMES];
   chain_type seg_ff [FRAMES];

   assign link[0] = '0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      pbl_cell #(.IDX(g)) u_cell (
         .clock(clock), .reset(reset), .op(op), .scan(scan),
         .chain_in(link[g]), .chain_out(link_out[g]));
      if ((g % SEG) == SEG - 1) begin : g_reg
         always_ff @(posedge clock) seg_ff[g] <= link_out[g];
         assign link[g+1] = seg_ff[g];
      end else begin : g_wire
         assign link[g+1] = link_out[g];
      end
   end

   assign result = link[FRAMES];
endmodule

>>> rtl/page_buffer_pool_lru.sv
// ----------------------------------------------------------------------------
// page_buffer_pool_lru
// Frame-table controller for a page cache: LRU victim choice with pin counts
// and dirty write-back.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | cmd, page_id
//  rsp     | out | kind, frame, page_num, last
//  csr     | in  | we, idx, wdata (dirty_high_mark, dirty_low_mark)
//
// Each scan of the cell row passes the chain registers placed every eight
// cells; a hit, fill, failure or unpin uses one scan. A fill over a dirty
// victim adds a second scan. Mark dirty uses one scan, plus one per write-back
// and one more once early write-back starts; flush all one scan per dirty
// frame plus one.
// Hold each write-back beat for one scan so that the final one carries last.
// Reset is synchronous; all cells clear their valid, dirty and pin state.
// A result waits in the output register while rsp_ready is low; the scan halts.
module page_buffer_pool_lru #(
   parameter int FRAMES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbl_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pbl_pkg::PAGE_W-1:0]    req_page_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pbl_pkg::KIND_W-1:0]    rsp_kind,
   output logic [pbl_pkg::FRAME_W-1:0]   rsp_frame,
   output logic [pbl_pkg::PAGE_W-1:0]    rsp_page_num,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [pbl_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [pbl_pkg::MARK_W-1:0]    csr_wdata
);
   import pbl_pkg::*;

   localparam int LAT   = (FRAMES + 7) / 8 + 1;
   localparam int CNT_W = $clog2(LAT + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [MARK_W-1:0]  high_ff, low_ff, cnt_dirty_ff, cnt_dirty_in;
   logic               evict_ff, evict_in, wbmode_ff, wbmode_in;
   logic [FRAME_W-1:0] hitf_ff, hitf_in;
   logic               hitok_ff, hitok_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PAGE_W-1:0]  pnum_ff, pnum_in;
   logic               last_ff, last_in, more_ff, more_in;
   logic               hold_ff, hold_in;
   logic [FRAME_W-1:0] hf_ff, hf_in;
   logic [PAGE_W-1:0]  hp_ff, hp_in;
   cell_op_type        op;
   scan_type           scan;
   chain_type          res;

   pbl_array #(.FRAMES(FRAMES)) u_array (
      .clock(clock), .reset(reset), .op(op), .scan(scan), .result(res));

   assign scan.page = page_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_kind = kind_ff;
   assign rsp_frame = frame_ff;
   assign rsp_page_num = pnum_ff;
   assign rsp_last = last_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      clock_in = clock_ff;
      cnt_dirty_in = cnt_dirty_ff;
      evict_in = evict_ff;
      wbmode_in = wbmode_ff;
      hitf_in = hitf_ff;
      hitok_in = hitok_ff;
      kind_in = kind_ff;
      frame_in = frame_ff;
      pnum_in = pnum_ff;
      last_in = last_ff;
      more_in = more_ff;
      hold_in = hold_ff;
      hf_in = hf_ff;
      hp_in = hp_ff;
      op = '0;
      op.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in = '0;
               evict_in = 1'b0;
               wbmode_in = 1'b0;
               hold_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LAT)) begin
               state_in = ST_OUT;
               more_in = 1'b0;
               last_in = 1'b1;
               pnum_in = page_ff;
               if (!wbmode_ff) begin
                  hitok_in = res.hit.found;
                  hitf_in = res.hit.frame;
                  cnt_dirty_in = res.dirty_cnt;
               end
               case (cmd_ff)
                  CMD_GET: begin
                     if (evict_ff) begin
                        clock_in = clock_ff + 1'b1;
                        op = '{op: OP_FILL, frame: frame_ff, page: page_ff,
                               stamp: clock_in};
                        kind_in = KIND_FILL;
                     end else if (res.hit.found) begin
                        clock_in = clock_ff + 1'b1;
                        op = '{op: OP_HIT, frame: res.hit.frame, page: page_ff,
                               stamp: clock_in};
                        kind_in = KIND_HIT;
                        frame_in = res.hit.frame;
                     end else if (res.inval.found) begin
                        clock_in = clock_ff + 1'b1;
                        op = '{op: OP_FILL, frame: res.inval.frame, page: page_ff,
                               stamp: clock_in};
                        kind_in = KIND_FILL;
                        frame_in = res.inval.frame;
                     end else if (!res.lru.found) begin
                        kind_in = KIND_FAIL;
                        frame_in = '0;
                     end else if (res.lru.dirty) begin
                        op = '{op: OP_CLEAN, frame: res.lru.frame, page: '0,
                               stamp: '0};
                        kind_in = KIND_WB;
                        frame_in = res.lru.frame;
                        pnum_in = res.lru.tag;
                        last_in = 1'b0;
                        more_in = 1'b1;
                        evict_in = 1'b1;
                     end else begin
                        clock_in = clock_ff + 1'b1;
                        op = '{op: OP_FILL, frame: res.lru.frame, page: page_ff,
                               stamp: clock_in};
                        kind_in = KIND_FILL;
                        frame_in = res.lru.frame;
                     end
                  end
                  CMD_UNPIN: begin
                     if (res.hit.found)
                        op = '{op: OP_UNPIN, frame: res.hit.frame, page: '0,
                               stamp: '0};
                     kind_in = KIND_DONE;
                     frame_in = res.hit.found ? res.hit.frame : '0;
                  end
                  CMD_DIRTY: begin
                     if (!wbmode_ff) begin
                        if (res.hit.found) begin
                           op = '{op: OP_DIRTY, frame: res.hit.frame, page: '0,
                                  stamp: '0};
                           if (!res.hit.dirty)
                              cnt_dirty_in = res.dirty_cnt + 1'b1;
                        end
                        wbmode_in = (high_ff != '0) && (cnt_dirty_in >= high_ff);
                        state_in = wbmode_in ? ST_SCAN : ST_OUT;
                        cnt_in = '0;
                        kind_in = KIND_DONE;
                        frame_in = res.hit.found ? res.hit.frame : '0;
                     end else if (cnt_dirty_ff > low_ff && res.lru_dirty.found) begin
                        op = '{op: OP_CLEAN, frame: res.lru_dirty.frame, page: '0,
                               stamp: '0};
                        cnt_dirty_in = cnt_dirty_ff - 1'b1;
                        hold_in = 1'b1;
                        hf_in = res.lru_dirty.frame;
                        hp_in = res.lru_dirty.tag;
                        if (hold_ff) begin
                           kind_in = KIND_WB;
                           frame_in = hf_ff;
                           pnum_in = hp_ff;
                           last_in = 1'b0;
                           more_in = 1'b1;
                        end else begin
                           state_in = ST_SCAN;
                           cnt_in = '0;
                        end
                     end else if (hold_ff) begin
                        hold_in = 1'b0;
                        kind_in = KIND_WB;
                        frame_in = hf_ff;
                        pnum_in = hp_ff;
                     end else begin
                        kind_in = KIND_DONE;
                        frame_in = hitok_ff ? hitf_ff : '0;
                     end
                  end
                  default: begin
                     if (res.first_dirty.found) begin
                        op = '{op: OP_CLEAN, frame: res.first_dirty.frame,
                               page: '0, stamp: '0};
                        hold_in = 1'b1;
                        hf_in = res.first_dirty.frame;
                        hp_in = res.first_dirty.tag;
                        if (hold_ff) begin
                           kind_in = KIND_WB;
                           frame_in = hf_ff;
                           pnum_in = hp_ff;
                           last_in = 1'b0;
                           more_in = 1'b1;
                        end else begin
                           state_in = ST_SCAN;
                           cnt_in = '0;
                        end
                     end else if (hold_ff) begin
                        hold_in = 1'b0;
                        kind_in = KIND_WB;
                        frame_in = hf_ff;
                        pnum_in = hp_ff;
                     end else begin
                        kind_in = KIND_DONE;
                        frame_in = '0;
                        pnum_in = '0;
                     end
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = more_ff ? ST_SCAN : ST_IDLE;
               cnt_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clock_ff <= '0;
         high_ff  <= MARK_W'(16);
         low_ff   <= MARK_W'(4);
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clock_ff <= clock_in;
         hold_ff  <= hold_in;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_HIGH: high_ff <= csr_wdata;
               CSR_LOW:  low_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page_id;
      end
      hf_ff <= hf_in;
      hp_ff <= hp_in;
      cnt_ff <= cnt_in;
      cnt_dirty_ff <= cnt_dirty_in;
      evict_ff <= evict_in;
      wbmode_ff <= wbmode_in;
      hitf_ff <= hitf_in;
      hitok_ff <= hitok_in;
      kind_ff <= kind_in;
      frame_ff <= frame_in;
      pnum_ff <= pnum_in;
      last_ff <= last_in;
      more_ff <= more_in;
   end
endmodule

>>> tb/page_buffer_pool_lru_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_buffer_pool_lru_tb
// Drives random and directed page requests into the frame table, predicts
// every hit, fill, write-back, failure and done beat with a scoreboard that
// keeps its own copy of the frame table, and checks each result beat in order
// under random stalls on both channels and several watermark settings.
// ----------------------------------------------------------------------------
module page_buffer_pool_lru_tb;
   import pbl_pkg::*;

   localparam int NFRAMES  = 64;
   localparam int POOL_SZ  = 96;
   localparam int IDLE_MAX = 5000;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page_num;
      logic               last;
   } rsp_beat_type;

   class frame_table_sb;
      logic [PAGE_W-1:0]  tags   [NFRAMES];
      bit                 vld    [NFRAMES];
      bit                 drt    [NFRAMES];
      logic [PIN_W-1:0]   pins   [NFRAMES];
      logic [STAMP_W-1:0] stamps [NFRAMES];
      logic [STAMP_W-1:0] tick;
      logic [MARK_W-1:0]  high_mark;
      logic [MARK_W-1:0]  low_mark;
      rsp_beat_type       due [$];
      int                 errors;
      int                 seen;

      function new();
         for (int i = 0; i < NFRAMES; i++) begin
            tags[i] = '0; vld[i] = 0; drt[i] = 0; pins[i] = '0; stamps[i] = '0;
         end
         tick = '0; high_mark = 7'd16; low_mark = 7'd4; errors = 0; seen = 0;
      endfunction

      function void set_mark(logic [CSR_IDX_W-1:0] idx, logic [MARK_W-1:0] v);
         if (idx == CSR_HIGH) high_mark = v;
         else low_mark = v;
      endfunction

      function int find(logic [PAGE_W-1:0] page);
         for (int i = 0; i < NFRAMES; i++)
            if (vld[i] && tags[i] == page) return i;
         return -1;
      endfunction

      function void push(logic [KIND_W-1:0] k, int f, logic [PAGE_W-1:0] p, bit l);
         rsp_beat_type b;
         b.kind = k; b.frame = f[FRAME_W-1:0]; b.page_num = p; b.last = l;
         due.push_back(b);
      endfunction

      function void note(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
         int hit, best, start;
         int unsigned cnt;
         start = due.size();
         hit = find(page);
         best = -1;
         case (cmd)
            CMD_GET: begin
               if (hit >= 0) begin
                  if (pins[hit] != 16'hFFFF) pins[hit]++;
                  tick++;
                  stamps[hit] = tick;
                  push(KIND_HIT, hit, page, 1);
                  return;
               end
               for (int i = 0; i < NFRAMES; i++)
                  if (!vld[i]) begin
                     best = i;
                     break;
                  end
               if (best < 0) begin
                  for (int i = 0; i < NFRAMES; i++)
                     if (pins[i] == 0 && (best < 0 || stamps[i] < stamps[best])) best = i;
                  if (best < 0) begin
                     push(KIND_FAIL, 0, page, 1);
                     return;
                  end
                  if (drt[best]) push(KIND_WB, best, tags[best], 0);
               end
               tags[best] = page; vld[best] = 1; drt[best] = 0; pins[best] = 1;
               tick++;
               stamps[best] = tick;
               push(KIND_FILL, best, page, 1);
            end
            CMD_UNPIN: begin
               if (hit >= 0 && pins[hit] > 0) pins[hit]--;
               push(KIND_DONE, hit >= 0 ? hit : 0, page, 1);
            end
            CMD_DIRTY: begin
               if (hit >= 0) drt[hit] = 1;
               if (high_mark != 0) begin
                  cnt = 0;
                  for (int i = 0; i < NFRAMES; i++)
                     if (vld[i] && drt[i]) cnt++;
                  if (cnt >= high_mark) begin
                     while (cnt > low_mark) begin
                        best = -1;
                        for (int i = 0; i < NFRAMES; i++)
                           if (vld[i] && drt[i] && pins[i] == 0 &&
                               (best < 0 || stamps[i] < stamps[best])) best = i;
                        if (best < 0) break;
                        drt[best] = 0;
                        push(KIND_WB, best, tags[best], 0);
                        cnt--;
                     end
                  end
               end
               if (due.size() == start) push(KIND_DONE, hit >= 0 ? hit : 0, page, 1);
               else due[due.size()-1].last = 1;
            end
            default: begin
               for (int i = 0; i < NFRAMES; i++)
                  if (vld[i] && drt[i]) begin
                     drt[i] = 0;
                     push(KIND_WB, i, tags[i], 0);
                  end
               if (due.size() == start) push(KIND_DONE, 0, '0, 1);
               else due[due.size()-1].last = 1;
            end
         endcase
      endfunction

      function void check(rsp_beat_type got);
         rsp_beat_type exp;
         seen++;
         if (due.size() == 0) begin
            $error("unexpected result beat kind %0d frame %0d page %h",
                   got.kind, got.frame, got.page_num);
            errors++;
            return;
         end
         exp = due.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind);
            errors++;
         end
         if (got.frame !== exp.frame) begin
            $error("frame: expected %0d, got %0d", exp.frame, got.frame);
            errors++;
         end
         if (got.page_num !== exp.page_num) begin
            $error("page_num: expected %h, got %h", exp.page_num, got.page_num);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [MARK_W-1:0]    csr_wdata;

   pbl_if #(.W(CMD_W + PAGE_W)) req_ch (clock);
   pbl_if #(.W(KIND_W + FRAME_W + PAGE_W + 1)) rsp_ch (clock);

   page_buffer_pool_lru #(.FRAMES(NFRAMES)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_cmd      (req_ch.data[PAGE_W +: CMD_W]),
      .req_page_id  (req_ch.data[PAGE_W-1:0]),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_kind     (rsp_ch.data[FRAME_W+PAGE_W+1 +: KIND_W]),
      .rsp_frame    (rsp_ch.data[PAGE_W+1 +: FRAME_W]),
      .rsp_page_num (rsp_ch.data[1 +: PAGE_W]),
      .rsp_last     (rsp_ch.data[0]),
      .csr_we       (csr_we),
      .csr_idx      (csr_idx),
      .csr_wdata    (csr_wdata)
   );

   frame_table_sb        table_sb;
   logic [PAGE_W-1:0]    page_pool [POOL_SZ];
   bit                   gaps_on;
   int                   idle_cycles;
   int                   items_sent;
   int                   rsp_stall;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random length gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_beat_type b;
            b.kind     = rsp_ch.data[FRAME_W+PAGE_W+1 +: KIND_W];
            b.frame    = rsp_ch.data[PAGE_W+1 +: FRAME_W];
            b.page_num = rsp_ch.data[1 +: PAGE_W];
            b.last     = rsp_ch.data[0];
            table_sb.check(b);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_stall = pick_gap();
            rsp_ch.ready <= (rsp_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("watchdog: no beat moved for %0d cycles", IDLE_MAX);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_req(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.data  <= {cmd, page};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      table_sb.note(cmd, page);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (table_sb.due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_mark(logic [CSR_IDX_W-1:0] idx, logic [MARK_W-1:0] v);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= v;
      @(posedge clock);
      table_sb.set_mark(idx, v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PAGE_W-1:0] pick_page();
      if ($urandom_range(0, 19) == 0) return $urandom();
      return page_pool[$urandom_range(0, POOL_SZ-1)];
   endfunction

   // weights are percentages for get, unpin and mark dirty; the rest flush
   task automatic random_phase(int count, int w_get, int w_unpin, int w_dirty);
      int r;
      logic [CMD_W-1:0] cmd;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < w_get) cmd = CMD_GET;
         else if (r < w_get + w_unpin) cmd = CMD_UNPIN;
         else if (r < w_get + w_unpin + w_dirty) cmd = CMD_DIRTY;
         else cmd = CMD_FLUSH;
         send_req(cmd, cmd == CMD_FLUSH ? $urandom() : pick_page());
      end
      gaps_on = 1;
   endtask

   initial begin
      table_sb     = new();
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_we       = 1'b0;
      csr_idx      = CSR_HIGH;
      csr_wdata    = '0;
      gaps_on      = 1;
      items_sent   = 0;
      for (int i = 0; i < POOL_SZ; i++)
         page_pool[i] = (i < 32) ? PAGE_W'(i) : $urandom();
      page_pool[32] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every command, empty and absent cases
      send_req(CMD_GET,   32'h0000_0000);
      send_req(CMD_GET,   32'hFFFF_FFFF);
      send_req(CMD_GET,   32'h0000_0000);
      send_req(CMD_DIRTY, 32'h0000_0000);
      send_req(CMD_UNPIN, 32'h0000_0000);
      send_req(CMD_UNPIN, 32'h0000_0000);
      send_req(CMD_UNPIN, 32'h0000_0000);
      send_req(CMD_UNPIN, 32'h0000_0005);
      send_req(CMD_DIRTY, 32'h0000_0007);
      send_req(CMD_FLUSH, 32'hFFFF_FFFF);
      send_req(CMD_FLUSH, 32'h0000_0000);
      send_req(CMD_GET,   32'hAAAA_AAAA);
      send_req(CMD_GET,   32'h5555_5555);
      send_req(CMD_DIRTY, 32'hFFFF_FFFF);
      send_req(CMD_DIRTY, 32'hAAAA_AAAA);
      send_req(CMD_UNPIN, 32'hFFFF_FFFF);
      send_req(CMD_FLUSH, 32'h1234_5678);
      drain();

      write_mark(CSR_HIGH, 7'd3);
      write_mark(CSR_LOW,  7'd1);
      random_phase(70, 45, 25, 25);
      drain();

      // fill and pin every frame so gets start to fail, then release
      write_mark(CSR_HIGH, 7'd0);
      write_mark(CSR_LOW,  7'd0);
      random_phase(110, 88, 2, 8);
      random_phase(90, 15, 70, 12);
      drain();

      write_mark(CSR_HIGH, 7'd64);
      write_mark(CSR_LOW,  7'd64);
      random_phase(60, 40, 35, 24);
      drain();

      write_mark(CSR_HIGH, 7'd1);
      write_mark(CSR_LOW,  7'd0);
      random_phase(50, 45, 30, 22);
      drain();

      write_mark(CSR_HIGH, 7'd8);
      write_mark(CSR_LOW,  7'd64);
      random_phase(40, 40, 30, 28);
      drain();

      write_mark(CSR_HIGH, 7'd16);
      write_mark(CSR_LOW,  7'd4);
      random_phase(40, 50, 25, 23);
      drain();

      $display("covered %0d requests, %0d result beats checked, six watermark settings",
               items_sent, table_sb.seen);
      if (table_sb.errors == 0 && table_sb.due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results still awaited",
                  table_sb.errors, table_sb.due.size());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

>>> page_buffer_pool_lru.f
rtl/pbl_pkg.sv
rtl/pbl_if.sv
rtl/pbl_cell.sv
rtl/pbl_array.sv
rtl/page_buffer_pool_lru.sv
tb/page_buffer_pool_lru_tb.sv
